>>> hw/rtl/epcal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epcal_pkg
// shared types and constants for the epoch seconds to calendar converter
// ----------------------------------------------------------------------------
package epcal_pkg;

    // field widths
    localparam int unsigned EpochW = 32;
    localparam int unsigned DaysW  = 16;
    localparam int unsigned TodW   = 17;
    localparam int unsigned MinsW  = 11;
    localparam int unsigned DataOW = 40;

    // register stages from input transfer to output register
    localparam int unsigned PipeStages = 8;

    // seconds per day split as 2^7 * 675
    localparam logic [22:0] C_DAY675_RECIP = 23'd6362914;   // floor(2^32 / 675)
    localparam logic [9:0]  C_DAY675       = 10'd675;
    localparam logic [16:0] C_SECS_PER_DAY = 17'd86400;

    // exact reciprocals for divide by 60
    localparam logic [17:0] C_DIV60_TOD    = 18'd139811;    // ceil(2^23 / 60), 17-bit dividend
    localparam logic [11:0] C_DIV60_MINS   = 12'd2185;      // ceil(2^17 / 60), 11-bit dividend
    localparam logic [5:0]  C_SIXTY        = 6'd60;

    // day count rebased to 1968-03-01, with a phantom 29 february 2100
    localparam logic [15:0] C_MAR1968_OFS  = 16'd671;
    localparam logic [15:0] C_MAR2100_DAY  = 16'd47541;     // days from epoch to 2100-03-01
    localparam logic [16:0] C_QUAD_RECIP   = 17'd91868;     // ceil(2^27 / 1461)
    localparam logic [10:0] C_QUAD_DAYS    = 11'd1461;
    localparam logic [10:0] C_YEAR_DAYS    = 11'd365;
    localparam logic [11:0] C_BASE_YEAR    = 12'd1968;

    // first day of each month, year starting on 1 march
    typedef logic [8:0] t_doy;
    localparam t_doy C_MONTH_START [12] = '{
        9'd0, 9'd31, 9'd61, 9'd92, 9'd122, 9'd153,
        9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337
    };
    localparam logic [3:0] C_MP_JANUARY = 4'd10;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } t_tod;

    typedef struct packed {
        logic [11:0] full_year;
        logic [3:0]  month_number;
        logic [4:0]  day_of_month;
    } t_date;

endpackage

>>> hw/rtl/epcal_tod.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epcal_tod
// five-stage split of seconds within the day into hour, minute and second
// ----------------------------------------------------------------------------
module epcal_tod (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [epcal_pkg::TodW-1:0]  i_tod,
    output epcal_pkg::t_tod             o_tod
);

    logic [34:0] w_pm;
    logic [16:0] w_m60;
    logic [16:0] w_sdiff;
    logic [22:0] w_ph;
    logic [10:0] w_h60;
    logic [10:0] w_mdiff;

    logic [epcal_pkg::MinsW-1:0] r4_mins;
    logic [epcal_pkg::TodW-1:0]  r4_tod;
    logic [epcal_pkg::MinsW-1:0] r5_mins;
    logic [5:0]                  r5_sec;
    logic [4:0]                  r5_hour;
    epcal_pkg::t_tod             n_t6;
    epcal_pkg::t_tod             r6_t;
    epcal_pkg::t_tod             r7_t;
    epcal_pkg::t_tod             r8_t;

    // total minutes
    assign w_pm = {18'd0, i_tod} * {17'd0, epcal_pkg::C_DIV60_TOD};

    // seconds left over, and hours from minutes
    assign w_m60   = {6'd0, r4_mins} * {11'd0, epcal_pkg::C_SIXTY};
    assign w_sdiff = r4_tod - w_m60;
    assign w_ph    = {12'd0, r4_mins} * {11'd0, epcal_pkg::C_DIV60_MINS};

    // minutes left over
    assign w_h60   = {6'd0, r5_hour} * {5'd0, epcal_pkg::C_SIXTY};
    assign w_mdiff = r5_mins - w_h60;

    always_comb begin
        n_t6.hour   = r5_hour;
        n_t6.minute = w_mdiff[5:0];
        n_t6.second = r5_sec;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_mins <= w_pm[33:23];
            r4_tod  <= i_tod;
            r5_mins <= r4_mins;
            r5_sec  <= w_sdiff[5:0];
            r5_hour <= w_ph[21:17];
            r6_t    <= n_t6;
            r7_t    <= r6_t;
            r8_t    <= r7_t;
        end
    end

    assign o_tod = r8_t;

endmodule

>>> hw/rtl/epcal_date.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epcal_date
// five-stage conversion of whole days since the epoch into year, month, day
// ----------------------------------------------------------------------------
module epcal_date (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [epcal_pkg::DaysW-1:0]  i_days,
    output epcal_pkg::t_date             o_date
);

    logic        w_adj;
    logic [15:0] n_e;
    logic [32:0] w_pq;
    logic [15:0] w_q1461;
    logic [15:0] w_rdiff;
    logic [1:0]  n_yq;
    logic [10:0] w_y365;
    logic [10:0] w_ddiff;
    logic [3:0]  n_mp;
    logic [8:0]  w_dd;
    epcal_pkg::t_date n_date;

    logic [15:0] r4_e;
    logic [15:0] r5_e;
    logic [5:0]  r5_quad;
    logic [5:0]  r6_quad;
    logic [10:0] r6_rem;
    logic [5:0]  r7_quad;
    logic [1:0]  r7_yq;
    logic [8:0]  r7_doy;
    epcal_pkg::t_date r8_date;

    // rebase to 1968-03-01 and skip the missing leap day of 2100
    assign w_adj = (i_days >= epcal_pkg::C_MAR2100_DAY);
    assign n_e   = i_days + epcal_pkg::C_MAR1968_OFS + {15'd0, w_adj};

    // four-year cycle number
    assign w_pq = {17'd0, r4_e} * {16'd0, epcal_pkg::C_QUAD_RECIP};

    // day within the cycle
    assign w_q1461 = {10'd0, r5_quad} * {5'd0, epcal_pkg::C_QUAD_DAYS};
    assign w_rdiff = r5_e - w_q1461;

    // year within the cycle, the fourth one holds the leap day
    always_comb begin
        if (r6_rem >= 11'd1095) begin
            n_yq = 2'd3;
        end else if (r6_rem >= 11'd730) begin
            n_yq = 2'd2;
        end else if (r6_rem >= epcal_pkg::C_YEAR_DAYS) begin
            n_yq = 2'd1;
        end else begin
            n_yq = 2'd0;
        end
    end
    assign w_y365  = {9'd0, n_yq} * epcal_pkg::C_YEAR_DAYS;
    assign w_ddiff = r6_rem - w_y365;

    // month from march-based day of year
    always_comb begin
        n_mp = '0;
        for (int k = 1; k < 12; k++) begin
            if (r7_doy >= epcal_pkg::C_MONTH_START[k]) begin
                n_mp = n_mp + 4'd1;
            end
        end
    end
    assign w_dd = r7_doy - epcal_pkg::C_MONTH_START[n_mp] + 9'd1;

    always_comb begin
        n_date.day_of_month = w_dd[4:0];
        if (n_mp >= epcal_pkg::C_MP_JANUARY) begin
            n_date.month_number = n_mp - 4'd9;
            n_date.full_year    = epcal_pkg::C_BASE_YEAR + {4'd0, r7_quad, 2'b00}
                                  + {10'd0, r7_yq} + 12'd1;
        end else begin
            n_date.month_number = n_mp + 4'd3;
            n_date.full_year    = epcal_pkg::C_BASE_YEAR + {4'd0, r7_quad, 2'b00}
                                  + {10'd0, r7_yq};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_e    <= n_e;
            r5_e    <= r4_e;
            r5_quad <= w_pq[32:27];
            r6_quad <= r5_quad;
            r6_rem  <= w_rdiff[10:0];
            r7_quad <= r6_quad;
            r7_yq   <= n_yq;
            r7_doy  <= w_ddiff[8:0];
            r8_date <= n_date;
        end
    end

    assign o_date = r8_date;

endmodule

>>> hw/rtl/epoch_seconds_to_calendar_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_top
// unsigned epoch seconds to gregorian date and time of day, pipelined
// ----------------------------------------------------------------------------
//  channel   direction  tdata bits   content
//  s_axis    in         31:0         epoch_seconds
//  m_axis    out        39:0         second, minute, hour, day_of_month,
//                                    month_number, full_year, zero pad
//
//  eight register stages, one transfer accepted per cycle while the output is not held back
//  three stages for the divide by 86400, then five for time of day and date
//  all stages advance together; a stalled output freezes the whole pipe,
//  so nothing is dropped or repeated, and bubbles are not squeezed out
//  reset clears the valid bits only; there is no clearing pass
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [epcal_pkg::EpochW-1:0]   s_axis_tdata,   // epoch_seconds[31:0]
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [epcal_pkg::DataOW-1:0]   m_axis_tdata    // second[5:0], minute[11:6],
                                                           // hour[16:12], day_of_month[21:17],
                                                           // month_number[25:22],
                                                           // full_year[37:26], zero[39:38]
);

    logic                                w_en;
    logic [epcal_pkg::PipeStages-1:0]    r_vld;

    // stage 1: coarse quotient of (seconds / 128) by 675
    logic [47:0] w_p1;
    logic [15:0] r1_qe;
    logic [24:0] r1_q1;
    logic [6:0]  r1_lo;

    // stage 2: back-multiply the estimate
    logic [25:0] n_prod2;
    logic [15:0] r2_qe;
    logic [24:0] r2_q1;
    logic [6:0]  r2_lo;
    logic [25:0] r2_prod;

    // stage 3: one correction step gives exact day count and second of day
    logic [24:0] w_rem;
    logic        w_fix;
    logic [9:0]  w_r675;
    logic [15:0] n_days;
    logic [15:0] r3_days;
    logic [16:0] r3_tod;

    epcal_pkg::t_tod  w_tod;
    epcal_pkg::t_date w_date;

    // the whole pipe moves unless a finished result is held back
    assign w_en          = !r_vld[epcal_pkg::PipeStages-1] || m_axis_tready;
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_vld[epcal_pkg::PipeStages-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[epcal_pkg::PipeStages-2:0], s_axis_tvalid};
        end
    end

    assign w_p1 = {23'd0, s_axis_tdata[31:7]} * {25'd0, epcal_pkg::C_DAY675_RECIP};

    assign n_prod2 = {10'd0, r1_qe} * {16'd0, epcal_pkg::C_DAY675};

    // estimate is low by at most one, so the remainder stays below 2 * 675
    assign w_rem  = r2_q1 - r2_prod[24:0];
    assign w_fix  = (w_rem[10:0] >= {1'b0, epcal_pkg::C_DAY675});
    assign w_r675 = w_fix ? 10'(w_rem[10:0] - {1'b0, epcal_pkg::C_DAY675})
                          : w_rem[9:0];
    assign n_days = r2_qe + {15'd0, w_fix};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_qe   <= w_p1[47:32];
            r1_q1   <= s_axis_tdata[31:7];
            r1_lo   <= s_axis_tdata[6:0];
            r2_qe   <= r1_qe;
            r2_q1   <= r1_q1;
            r2_lo   <= r1_lo;
            r2_prod <= n_prod2;
            r3_days <= n_days;
            r3_tod  <= {w_r675, r2_lo};
        end
    end

    // stages 4 to 8
    epcal_tod u_tod (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_tod (r3_tod),
        .o_tod (w_tod)
    );

    epcal_date u_date (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_days (r3_days),
        .o_date (w_date)
    );

    assign m_axis_tdata = {2'b00,
                           w_date.full_year,
                           w_date.month_number,
                           w_date.day_of_month,
                           w_tod.hour,
                           w_tod.minute,
                           w_tod.second};

    // reciprocal estimate never falls more than one below the true quotient
    a_rem_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] |-> (w_rem < 25'd1350))
        else $error("day divide remainder out of range");

    a_tod_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] |-> (r3_tod < epcal_pkg::C_SECS_PER_DAY))
        else $error("second of day out of range");

    a_time_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_tod.hour < 5'd24 && w_tod.minute < 6'd60
                           && w_tod.second < 6'd60))
        else $error("time of day out of range");

    a_date_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (w_date.month_number != 4'd0 && w_date.month_number < 4'd13
                           && w_date.day_of_month != 5'd0
                           && w_date.full_year >= 12'd1970 && w_date.full_year <= 12'd2106))
        else $error("calendar date out of range");

endmodule
